// File: hw/rtl/rfq_pkg.sv
// shared types and codes for the rectangle fill queue
package rfq_pkg;

   localparam int QueueDepthDefault  = 16;
   localparam int TargetCountDefault = 2;

   localparam int CoordW = 12;
   localparam int CountW = 25;

   // register indexes on the csr port
   localparam logic [2:0] CSR_FIRST_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_FIRST_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_SECOND_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_SECOND_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_ENABLE_MASK   = 3'd4;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DRAIN   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_FILL       = 2'd0,
      KIND_INVALIDATE = 2'd1,
      KIND_DONE       = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CLIP,
      ST_MULT,
      ST_EMIT,
      ST_INVAL,
      ST_STATUS
   } state_type;

   // one queued command
   typedef struct packed {
      logic        target;
      logic [15:0] color;
      logic [15:0] left;
      logic [15:0] top;
      logic [14:0] width;
      logic [14:0] height;
   } entry_type;

   typedef struct packed {
      logic [CoordW-1:0] left;
      logic [CoordW-1:0] top;
      logic [CoordW-1:0] right;
      logic [CoordW-1:0] bottom;
   } box_type;

   typedef struct packed {
      kind_type          kind;
      logic              target;
      box_type           box;
      logic [15:0]       color;
      logic [CountW-1:0] count;
      logic [5:0]        pending;
      logic [31:0]       dropped;
      logic              last;
   } rsp_type;

endpackage

// File: hw/rtl/rect_fill_queue_with_dirty_box_top.sv
// ring queue of rectangle fill commands with clipping and dirty box tracking
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_ready  | enqueue or drain command
//   rsp     | out       | rsp_valid/rsp_ready  | fill, invalidate or drain status
//   csr     | in        | csr_write_en         | one register write, no wait
//
// req_ready is high only while the block is idle, so commands are taken only there.
// a drain steps through memory read, clip, multiply and emit for each popped
// command, only read and clip for a discarded one, and at the end a final
// check, one invalidate step per target and status, then returns to idle.
// the command memory port and the single result register set these steps.
// a stalled rsp side holds the sequencer in its emit, invalidate or status
// state; nothing is lost.
// synchronous reset empties the ring and clears the dropped counter, dirty flags and csrs.
module rect_fill_queue_with_dirty_box_top #(
   parameter int QUEUE_DEPTH  = rfq_pkg::QueueDepthDefault,
   parameter int TARGET_COUNT = rfq_pkg::TargetCountDefault
) (
   input  logic                clock,
   input  logic                reset,
   // command channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [1:0]          req_target_index,
   input  logic signed [15:0]  req_left,
   input  logic signed [15:0]  req_top,
   input  logic [14:0]         req_rect_width,
   input  logic [14:0]         req_rect_height,
   input  logic [15:0]         req_fill_color,
   input  logic [31:0]         req_pixel_budget,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_result_kind,
   output logic                rsp_out_target,
   output logic [11:0]         rsp_box_left,
   output logic [11:0]         rsp_box_top,
   output logic [11:0]         rsp_box_right,
   output logic [11:0]         rsp_box_bottom,
   output logic [15:0]         rsp_out_color,
   output logic [24:0]         rsp_pixel_count,
   output logic [5:0]          rsp_pending_count,
   output logic [31:0]         rsp_dropped_count,
   output logic                rsp_last,
   // register write port
   input  logic                csr_write_en,
   input  logic [2:0]          csr_index,
   input  logic [11:0]         csr_wdata
);
   import rfq_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   // command memory
   entry_type mem [QUEUE_DEPTH];
   logic            mem_we;
   logic [PtrW-1:0] mem_waddr;
   entry_type       mem_wdata;
   logic            mem_re;
   entry_type       rd_ff;

   state_type       state_ff, state_in;
   logic [PtrW-1:0] head_ff, head_in;
   logic [PtrW-1:0] tail_ff, tail_in;
   logic [31:0]     drop_ff, drop_in;
   logic [1:0]      dirty_ff, dirty_in;
   box_type         dbox_ff [2];
   box_type         dbox_in [2];
   logic [11:0]     tw_ff [2];
   logic [11:0]     tw_in [2];
   logic [11:0]     th_ff [2];
   logic [11:0]     th_in [2];
   logic [1:0]      en_ff, en_in;
   logic [31:0]     budget_ff, budget_in;
   logic [31:0]     spent_ff, spent_in;
   box_type         box_ff, box_in;
   logic            tgt_ff, tgt_in;
   logic [15:0]     color_ff, color_in;
   logic [CountW-1:0] count_ff, count_in;
   logic            inv_ff, inv_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   // clip datapath on the word read from memory
   logic signed [17:0] cx0, cy0, cx1, cy1, limx, limy, x0c, y0c, x1c, y1c;
   logic               clip_empty;
   // multiply and spend
   logic [12:0]        dx, dy;
   logic [25:0]        prod;
   logic [32:0]        spent_sum;
   // ring helpers
   logic [PtrW-1:0]    head_next, tail_next;
   logic [PtrW:0]      pend_w;
   logic               slot_free;
   logic               req_take;
   logic               enq_ok;

   assign head_next = (head_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign pend_w    = (head_ff >= tail_ff)
                      ? ({1'b0, head_ff} - {1'b0, tail_ff})
                      : ({1'b0, head_ff} + (PtrW + 1)'(QUEUE_DEPTH) - {1'b0, tail_ff});

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign enq_ok    = ({1'b0, req_target_index} < 3'(TARGET_COUNT))
                      && (req_rect_width != '0) && (req_rect_height != '0);

   always_comb begin
      cx0  = $signed({{2{rd_ff.left[15]}}, rd_ff.left});
      cy0  = $signed({{2{rd_ff.top[15]}}, rd_ff.top});
      cx1  = cx0 + $signed({3'b000, rd_ff.width}) - 18'sd1;
      cy1  = cy0 + $signed({3'b000, rd_ff.height}) - 18'sd1;
      limx = $signed({6'b0, tw_ff[rd_ff.target]}) - 18'sd1;
      limy = $signed({6'b0, th_ff[rd_ff.target]}) - 18'sd1;
      x0c  = (cx0 < 18'sd0) ? 18'sd0 : cx0;
      y0c  = (cy0 < 18'sd0) ? 18'sd0 : cy0;
      x1c  = (cx1 > limx) ? limx : cx1;
      y1c  = (cy1 > limy) ? limy : cy1;
      clip_empty = (x1c < x0c) || (y1c < y0c);
   end

   assign dx        = {1'b0, box_ff.right} - {1'b0, box_ff.left} + 13'd1;
   assign dy        = {1'b0, box_ff.bottom} - {1'b0, box_ff.top} + 13'd1;
   assign prod      = dx * dy;
   assign spent_sum = {1'b0, spent_ff} + 33'(count_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      drop_in      = drop_ff;
      dirty_in     = dirty_ff;
      dbox_in      = dbox_ff;
      tw_in        = tw_ff;
      th_in        = th_ff;
      en_in        = en_ff;
      budget_in    = budget_ff;
      spent_in     = spent_ff;
      box_in       = box_ff;
      tgt_in       = tgt_ff;
      color_in     = color_ff;
      count_in     = count_ff;
      inv_in       = inv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = head_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FIRST_WIDTH:   tw_in[0] = csr_wdata;
            CSR_FIRST_HEIGHT:  th_in[0] = csr_wdata;
            CSR_SECOND_WIDTH:  tw_in[1] = csr_wdata;
            CSR_SECOND_HEIGHT: th_in[1] = csr_wdata;
            CSR_ENABLE_MASK:   en_in    = csr_wdata[1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_opcode == OP_ENQUEUE) begin
                  if (enq_ok) begin
                     mem_we           = 1'b1;
                     mem_wdata.target = req_target_index[0];
                     mem_wdata.color  = req_fill_color;
                     mem_wdata.left   = req_left;
                     mem_wdata.top    = req_top;
                     mem_wdata.width  = req_rect_width;
                     mem_wdata.height = req_rect_height;
                     head_in          = head_next;
                     // full ring: the oldest command goes
                     if (head_next == tail_ff) begin
                        tail_in = tail_next;
                        drop_in = drop_ff + 32'd1;
                     end
                  end
               end else begin
                  budget_in = req_pixel_budget;
                  spent_in  = '0;
                  state_in  = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if ((tail_ff != head_ff) && (spent_ff < budget_ff)) begin
               mem_re   = 1'b1;
               tail_in  = tail_next;
               state_in = ST_CLIP;
            end else begin
               inv_in   = 1'b0;
               state_in = ST_INVAL;
            end
         end
         ST_CLIP: begin
            if (!en_ff[rd_ff.target] || clip_empty) begin
               state_in = ST_CHECK;
            end else begin
               box_in.left   = x0c[11:0];
               box_in.top    = y0c[11:0];
               box_in.right  = x1c[11:0];
               box_in.bottom = y1c[11:0];
               tgt_in        = rd_ff.target;
               color_in      = rd_ff.color;
               state_in      = ST_MULT;
            end
         end
         ST_MULT: begin
            count_in = prod[CountW-1:0];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.kind   = KIND_FILL;
               rsp_in.target = tgt_ff;
               rsp_in.box    = box_ff;
               rsp_in.color  = color_ff;
               rsp_in.count  = count_ff;
               spent_in      = spent_sum[32] ? 32'hFFFF_FFFF : spent_sum[31:0];
               if (!dirty_ff[tgt_ff]) begin
                  dbox_in[tgt_ff]  = box_ff;
                  dirty_in[tgt_ff] = 1'b1;
               end else begin
                  if (box_ff.left < dbox_ff[tgt_ff].left)
                     dbox_in[tgt_ff].left = box_ff.left;
                  if (box_ff.top < dbox_ff[tgt_ff].top)
                     dbox_in[tgt_ff].top = box_ff.top;
                  if (box_ff.right > dbox_ff[tgt_ff].right)
                     dbox_in[tgt_ff].right = box_ff.right;
                  if (box_ff.bottom > dbox_ff[tgt_ff].bottom)
                     dbox_in[tgt_ff].bottom = box_ff.bottom;
               end
               state_in = ST_CHECK;
            end
         end
         ST_INVAL: begin
            // a dirty but disabled target keeps its box
            if (dirty_ff[inv_ff] && en_ff[inv_ff] && !slot_free) begin
               state_in = ST_INVAL;
            end else begin
               if (dirty_ff[inv_ff] && en_ff[inv_ff]) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in           = '0;
                  rsp_in.kind      = KIND_INVALIDATE;
                  rsp_in.target    = inv_ff;
                  rsp_in.box       = dbox_ff[inv_ff];
                  dirty_in[inv_ff] = 1'b0;
               end
               if (inv_ff == 1'(TARGET_COUNT - 1)) begin
                  state_in = ST_STATUS;
               end else begin
                  inv_in = inv_ff + 1'b1;
               end
            end
         end
         ST_STATUS: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in         = '0;
               rsp_in.kind    = KIND_DONE;
               rsp_in.pending = 6'(pend_w);
               rsp_in.dropped = drop_ff;
               rsp_in.last    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         drop_ff      <= '0;
         dirty_ff     <= '0;
         tw_ff[0]     <= '0;
         tw_ff[1]     <= '0;
         th_ff[0]     <= '0;
         th_ff[1]     <= '0;
         en_ff        <= '0;
         inv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         drop_ff      <= drop_in;
         dirty_ff     <= dirty_in;
         tw_ff        <= tw_in;
         th_ff        <= th_in;
         en_ff        <= en_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and payload, no reset needed
   always_ff @(posedge clock) begin
      dbox_ff   <= dbox_in;
      budget_ff <= budget_in;
      spent_ff  <= spent_in;
      box_ff    <= box_in;
      tgt_ff    <= tgt_in;
      color_ff  <= color_in;
      count_ff  <= count_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_ff.kind;
   assign rsp_out_target    = rsp_ff.target;
   assign rsp_box_left      = rsp_ff.box.left;
   assign rsp_box_top       = rsp_ff.box.top;
   assign rsp_box_right     = rsp_ff.box.right;
   assign rsp_box_bottom    = rsp_ff.box.bottom;
   assign rsp_out_color     = rsp_ff.color;
   assign rsp_pixel_count   = rsp_ff.count;
   assign rsp_pending_count = rsp_ff.pending;
   assign rsp_dropped_count = rsp_ff.dropped;
   assign rsp_last          = rsp_ff.last;

endmodule

// File: tb/rect_fill_queue_with_dirty_box_top_test.sv
// self-checking testbench for the rectangle fill queue with dirty box tracking
module rect_fill_queue_with_dirty_box_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rfq_pkg::*;

   localparam int QDEPTH        = QueueDepthDefault;
   localparam int TARGETS       = TargetCountDefault;
   localparam int SETTLE_CYCLES = 4 * QDEPTH + TARGETS + 4;
   localparam int HOLD_CYCLES   = 400;
   localparam int TIMEOUT_NS    = 6_000_000;

   typedef struct {
      op_type             op;
      logic [1:0]         target;
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [14:0]        width;
      logic [14:0]        height;
      logic [15:0]        color;
      logic [31:0]        budget;
   } fill_cmd_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_opcode = 1'b0;
   logic [1:0]         req_target_index = '0;
   logic signed [15:0] req_left = '0;
   logic signed [15:0] req_top = '0;
   logic [14:0]        req_rect_width = '0;
   logic [14:0]        req_rect_height = '0;
   logic [15:0]        req_fill_color = '0;
   logic [31:0]        req_pixel_budget = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_result_kind;
   logic               rsp_out_target;
   logic [11:0]        rsp_box_left;
   logic [11:0]        rsp_box_top;
   logic [11:0]        rsp_box_right;
   logic [11:0]        rsp_box_bottom;
   logic [15:0]        rsp_out_color;
   logic [24:0]        rsp_pixel_count;
   logic [5:0]         rsp_pending_count;
   logic [31:0]        rsp_dropped_count;
   logic               rsp_last;
   logic               csr_write_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [11:0]        csr_wdata = '0;

   rect_fill_queue_with_dirty_box_top u_top (.*);

   // shadow of the command ring, dirty boxes and canvas registers
   entry_type   ring_model [QDEPTH];
   int unsigned ring_head = 0;
   int unsigned ring_tail = 0;
   logic [31:0] drop_total = '0;
   bit          dirty_valid [TARGETS];
   int          dirty_box [TARGETS][4];
   logic [11:0] canvas_w [TARGETS];
   logic [11:0] canvas_h [TARGETS];
   logic [1:0]  enable_mask = '0;
   rsp_type     predicted_results [$];

   int error_count      = 0;
   int results_checked  = 0;
   int commands_sent    = 0;
   int drains_sent      = 0;
   int settings_written = 0;
   int stall_left       = 0;
   int hold_left        = 0;
   bit hold_request     = 1'b0;
   bit quiet_run        = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      for (int t = 0; t < TARGETS; t++) begin
         canvas_w[t]    = '0;
         canvas_h[t]    = '0;
         dirty_valid[t] = 1'b0;
      end
   end

   function automatic void push_result(kind_type kind, int tgt, int l, int t, int r, int b,
         logic [15:0] color, logic [24:0] count, logic [5:0] pend, logic [31:0] drop,
         logic last);
      rsp_type res;
      res.kind       = kind;
      res.target     = tgt[0];
      res.box.left   = l[11:0];
      res.box.top    = t[11:0];
      res.box.right  = r[11:0];
      res.box.bottom = b[11:0];
      res.color      = color;
      res.count      = count;
      res.pending    = pend;
      res.dropped    = drop;
      res.last       = last;
      predicted_results.push_back(res);
   endfunction

   function automatic void predict_command(fill_cmd_type cmd);
      int              x0, y0, x1, y1, tgt;
      int unsigned     nxt;
      longint unsigned spent, cnt;
      entry_type       e;
      if (cmd.op == OP_ENQUEUE) begin
         if (cmd.target >= TARGETS || cmd.width == 0 || cmd.height == 0) return;
         nxt = (ring_head + 1) % QDEPTH;
         // full ring loses its oldest command
         if (nxt == ring_tail) begin
            ring_tail = (ring_tail + 1) % QDEPTH;
            drop_total++;
         end
         e.target = cmd.target[0];
         e.color  = cmd.color;
         e.left   = cmd.left;
         e.top    = cmd.top;
         e.width  = cmd.width;
         e.height = cmd.height;
         ring_model[ring_head] = e;
         ring_head = nxt;
         return;
      end
      spent = 0;
      while (ring_tail != ring_head && spent < cmd.budget) begin
         e = ring_model[ring_tail];
         ring_tail = (ring_tail + 1) % QDEPTH;
         tgt = int'(e.target);
         if (!enable_mask[tgt]) continue;
         x0 = int'($signed(e.left));
         y0 = int'($signed(e.top));
         x1 = x0 + int'(e.width) - 1;
         y1 = y0 + int'(e.height) - 1;
         if (x0 < 0) x0 = 0;
         if (y0 < 0) y0 = 0;
         if (x1 > int'(canvas_w[tgt]) - 1) x1 = int'(canvas_w[tgt]) - 1;
         if (y1 > int'(canvas_h[tgt]) - 1) y1 = int'(canvas_h[tgt]) - 1;
         if (x1 < x0 || y1 < y0) continue;
         cnt = longint'(x1 - x0 + 1) * longint'(y1 - y0 + 1);
         if (spent + cnt > 64'hFFFF_FFFF) spent = 64'hFFFF_FFFF;
         else spent += cnt;
         push_result(KIND_FILL, tgt, x0, y0, x1, y1, e.color, 25'(cnt), '0, '0, 1'b0);
         if (!dirty_valid[tgt]) begin
            dirty_box[tgt][0] = x0;
            dirty_box[tgt][1] = y0;
            dirty_box[tgt][2] = x1;
            dirty_box[tgt][3] = y1;
            dirty_valid[tgt] = 1'b1;
         end else begin
            if (x0 < dirty_box[tgt][0]) dirty_box[tgt][0] = x0;
            if (y0 < dirty_box[tgt][1]) dirty_box[tgt][1] = y0;
            if (x1 > dirty_box[tgt][2]) dirty_box[tgt][2] = x1;
            if (y1 > dirty_box[tgt][3]) dirty_box[tgt][3] = y1;
         end
      end
      for (int t = 0; t < TARGETS; t++) begin
         // a disabled target keeps its dirty box for a later drain
         if (dirty_valid[t] && enable_mask[t]) begin
            push_result(KIND_INVALIDATE, t, dirty_box[t][0], dirty_box[t][1],
                        dirty_box[t][2], dirty_box[t][3], '0, '0, '0, '0, 1'b0);
            dirty_valid[t] = 1'b0;
         end
      end
      push_result(KIND_DONE, 0, 0, 0, 0, 0, '0, '0,
                  6'((ring_head + QDEPTH - ring_tail) % QDEPTH), drop_total, 1'b1);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_results.size() == 0) begin
            $error("result beat with nothing expected, kind %0d", rsp_result_kind);
            error_count++;
         end else begin
            want = predicted_results.pop_front();
            check_field("result_kind", want.kind, rsp_result_kind);
            check_field("out_target", want.target, rsp_out_target);
            check_field("box_left", want.box.left, rsp_box_left);
            check_field("box_top", want.box.top, rsp_box_top);
            check_field("box_right", want.box.right, rsp_box_right);
            check_field("box_bottom", want.box.bottom, rsp_box_bottom);
            check_field("out_color", want.color, rsp_out_color);
            check_field("pixel_count", want.count, rsp_pixel_count);
            check_field("pending_count", want.pending, rsp_pending_count);
            check_field("dropped_count", want.dropped, rsp_dropped_count);
            check_field("last", want.last, rsp_last);
            results_checked++;
         end
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic fill_cmd_type random_fields();
      fill_cmd_type c;
      c.op     = op_type'($urandom_range(0, 1));
      c.target = 2'($urandom);
      c.left   = 16'($urandom);
      c.top    = 16'($urandom);
      c.width  = 15'($urandom);
      c.height = 15'($urandom);
      c.color  = 16'($urandom);
      c.budget = $urandom;
      return c;
   endfunction

   function automatic fill_cmd_type make_enqueue(int tgt, int l, int t, int w, int h,
                                                 logic [15:0] color);
      fill_cmd_type c;
      c        = random_fields();
      c.op     = OP_ENQUEUE;
      c.target = 2'(tgt);
      c.left   = 16'(l);
      c.top    = 16'(t);
      c.width  = 15'(w);
      c.height = 15'(h);
      c.color  = color;
      return c;
   endfunction

   function automatic fill_cmd_type make_drain(logic [31:0] budget);
      fill_cmd_type c;
      c        = random_fields();
      c.op     = OP_DRAIN;
      c.budget = budget;
      return c;
   endfunction

   // rectangles mostly on or near the canvas, now and then anywhere
   function automatic fill_cmd_type random_enqueue();
      fill_cmd_type c;
      int           tgt, span_w, span_h;
      tgt    = $urandom_range(0, TARGETS - 1);
      span_w = int'(canvas_w[tgt]) + 64;
      span_h = int'(canvas_h[tgt]) + 64;
      c = make_enqueue(tgt, int'($urandom_range(0, span_w)) - 32,
                       int'($urandom_range(0, span_h)) - 32,
                       $urandom_range(1, 300), $urandom_range(1, 300), 16'($urandom));
      if ($urandom_range(0, 7) == 0) begin
         c.left   = 16'($urandom);
         c.top    = 16'($urandom);
         c.width  = 15'($urandom_range(1, 32767));
         c.height = 15'($urandom_range(1, 32767));
      end
      return c;
   endfunction

   function automatic logic [31:0] random_budget();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(1, 20000);
      endcase
   endfunction

   task automatic send_command(fill_cmd_type cmd);
      int gap;
      gap = 0;
      if (!quiet_run && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_opcode       <= cmd.op;
      req_target_index <= cmd.target;
      req_left         <= cmd.left;
      req_top          <= cmd.top;
      req_rect_width   <= cmd.width;
      req_rect_height  <= cmd.height;
      req_fill_color   <= cmd.color;
      req_pixel_budget <= cmd.budget;
      do @(posedge clock); while (!req_ready);
      predict_command(cmd);
      commands_sent++;
      if (cmd.op == OP_DRAIN) drains_sent++;
   endtask

   // release the command channel and let the block run dry
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (predicted_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [11:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock) csr_write_en <= 1'b0;
      case (idx)
         CSR_FIRST_WIDTH:   canvas_w[0] = value;
         CSR_FIRST_HEIGHT:  canvas_h[0] = value;
         CSR_SECOND_WIDTH:  canvas_w[1] = value;
         CSR_SECOND_HEIGHT: canvas_h[1] = value;
         CSR_ENABLE_MASK:   enable_mask = value[1:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [11:0] w0, logic [11:0] h0, logic [11:0] w1,
                            logic [11:0] h1, logic [1:0] mask);
      wait_idle();
      write_register(CSR_FIRST_WIDTH, w0);
      write_register(CSR_FIRST_HEIGHT, h0);
      write_register(CSR_SECOND_WIDTH, w1);
      write_register(CSR_SECOND_HEIGHT, h1);
      write_register(CSR_ENABLE_MASK, 12'(mask));
      settings_written++;
   endtask

   task automatic test_empty_drain();
      send_command(make_drain('0));
      send_command(make_drain(32'hFFFF_FFFF));
   endtask

   task automatic test_clipping_cases();
      configure(12'd640, 12'd480, 12'd4095, 12'd4095, 2'b11);
      send_command(make_enqueue(0, 10, 20, 100, 50, 16'hF800));
      send_command(make_enqueue(0, -5, -7, 20, 20, 16'h07E0));
      send_command(make_enqueue(0, 600, 470, 100, 100, 16'h001F));
      // wide corner maths: far negative corner still ends left of the canvas
      send_command(make_enqueue(1, -32768, -32768, 32767, 32767, 16'hFFFF));
      send_command(make_enqueue(1, 32767, 32767, 32767, 32767, 16'h0000));
      send_command(make_enqueue(1, -100, -100, 32767, 32767, 16'h1234));
      send_command(make_enqueue(0, 700, 0, 10, 10, 16'hABCD));
      // ignored: empty size and targets that do not exist
      send_command(make_enqueue(0, 1, 1, 0, 5, 16'h1111));
      send_command(make_enqueue(1, 1, 1, 5, 0, 16'h2222));
      send_command(make_enqueue(2, 1, 1, 5, 5, 16'h3333));
      send_command(make_enqueue(3, 1, 1, 5, 5, 16'h4444));
      send_command(make_drain(32'hFFFF_FFFF));
      send_command(make_enqueue(0, 0, 0, 1, 1, 16'h5555));
      send_command(make_enqueue(0, 639, 479, 1, 1, 16'h6666));
      send_command(make_enqueue(1, 4094, 0, 1, 4095, 16'h7777));
      send_command(make_drain('0));
      send_command(make_drain(32'd1));
      send_command(make_drain(32'hFFFF_FFFF));
      // target one switched off, then no target at all
      configure(12'd640, 12'd480, 12'd4095, 12'd4095, 2'b01);
      send_command(make_enqueue(1, 0, 0, 8, 8, 16'h8888));
      send_command(make_enqueue(0, 3, 3, 8, 8, 16'h9999));
      send_command(make_drain(32'hFFFF_FFFF));
      configure(12'd0, 12'd480, 12'd4095, 12'd0, 2'b00);
      send_command(make_enqueue(0, 0, 0, 8, 8, 16'hAAAA));
      send_command(make_drain(32'hFFFF_FFFF));
      // zero sized canvases clip everything away
      configure(12'd0, 12'd480, 12'd4095, 12'd0, 2'b11);
      send_command(make_enqueue(0, 0, 0, 8, 8, 16'hBBBB));
      send_command(make_enqueue(1, 0, 0, 8, 8, 16'hCCCC));
      send_command(make_drain(32'hFFFF_FFFF));
   endtask

   task automatic test_ring_overflow();
      configure(12'd320, 12'd240, 12'd200, 12'd100, 2'b11);
      repeat (QDEPTH + 4) send_command(random_enqueue());
      send_command(make_drain($urandom_range(1, 5000)));
      send_command(make_drain(32'hFFFF_FFFF));
   endtask

   task automatic test_receiver_hold();
      wait_idle();
      repeat (QDEPTH - 1) send_command(random_enqueue());
      hold_request = 1'b1;
      // the drain stalls on its results while the next commands wait behind it
      send_command(make_drain(32'hFFFF_FFFF));
      repeat (4) send_command(random_enqueue());
      send_command(make_drain(32'hFFFF_FFFF));
   endtask

   task automatic test_random_traffic();
      fill_cmd_type c;
      int           effective, pick;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: configure(12'd4095, 12'd4095, 12'd4095, 12'd4095, 2'b11);
            1: configure(12'($urandom_range(1, 700)), 12'($urandom_range(1, 500)),
                         12'($urandom_range(1, 700)), 12'($urandom_range(1, 500)),
                         2'($urandom));
            2: configure(12'd0, 12'd4095, 12'd1, 12'd4095, 2'b11);
            default: configure(12'($urandom), 12'($urandom), 12'($urandom_range(1, 900)),
                               12'($urandom_range(1, 900)), 2'($urandom));
         endcase
         if (phase == 3) quiet_run = 1'b1;
         effective = 0;
         while (effective < 7) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) c = random_enqueue();
            else if (pick < 7) c = random_fields();
            else c = make_drain(random_budget());
            send_command(c);
            if (!(c.op == OP_ENQUEUE &&
                  (c.target >= TARGETS || c.width == 0 || c.height == 0)))
               effective++;
         end
         send_command(make_drain(32'hFFFF_FFFF));
      end
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_empty_drain();
      test_clipping_cases();
      test_ring_overflow();
      test_receiver_hold();
      test_random_traffic();
      wait_idle();
      $display("sent %0d commands (%0d drains) under %0d canvas settings",
               commands_sent, drains_sent, settings_written);
      $display("checked %0d result beats, ring overflow dropped %0d commands",
               results_checked, drop_total);
      if (error_count == 0) begin
         $display("rect_fill_queue_with_dirty_box_top_test OK");
      end else begin
         $display("rect_fill_queue_with_dirty_box_top_test NOT OK");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timed out with %0d results outstanding", predicted_results.size());
      $display("rect_fill_queue_with_dirty_box_top_test NOT OK");
      $finish;
   end

endmodule
